### rtl/pkib_pkg.sv
package pkib_pkg;

   localparam int KEY_W = 32;
   localparam int TS_W  = 32;
   localparam int THR_W = 7;
   localparam int CNT_W = 7;
   localparam int CSR_W = 2;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [CSR_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INC_WINDOW = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BLK_WINDOW = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = 7'd5;
   localparam logic [TS_W-1:0]  WIN_RESET = 32'd60000;
   localparam logic [CNT_W-1:0] CNT_SAT   = 7'd127;

   // result of one pass through the shared age/key compare unit
   typedef struct packed {
      logic [TS_W-1:0] age;
      logic            expired;
      logic            key_eq;
   } cmp_res_type;

endpackage

### rtl/per_key_incident_breaker.sv
// Per-account incident breaker with sliding-window expiry.
// Request channel: start with req_opcode (0 report, 1 query), req_account_key
// and req_now_ms; a transaction is taken on a clock edge with start high and
// busy low. busy stays high until the result is produced.
// Result channel: rsp_valid strobes for one cycle with rsp_allowed,
// rsp_blocked_now, rsp_incident_count and rsp_overflowed. There is no
// back-pressure; the receiver must take the strobe.
// CSR channel: csr_valid/csr_ready with csr_index (0 threshold, 1 incident
// window, 2 block window) and csr_wdata; csr_ready is always high. Write only
// while busy is low and no result is pending.
// Timing: one block-table pass (one entry a cycle) then one ring compaction pass
// (one ring entry a cycle, one read and one write port) over the L live incidents
// held before the transaction (at most INCIDENT_DEPTH, 64 with defaults) set the
// time from accept to strobe; a new transaction may be started in the strobe cycle.
// Reset: synchronous, empties the ring and the block table and loads the
// default thresholds; it takes effect at once, no clearing pass.
module per_key_incident_breaker
   import pkib_pkg::*;
#(
   parameter int INCIDENT_DEPTH = 64,
   parameter int BLOCK_DEPTH    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_opcode,
   input  logic [KEY_W-1:0]  req_account_key,
   input  logic [TS_W-1:0]   req_now_ms,
   output logic              rsp_valid,
   output logic              rsp_allowed,
   output logic              rsp_blocked_now,
   output logic [CNT_W-1:0]  rsp_incident_count,
   output logic              rsp_overflowed,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int RA = $clog2(INCIDENT_DEPTH);
   localparam int RC = RA + 1;
   localparam int BA = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int BC = BA + 1;
   localparam int EW = KEY_W + TS_W;

   localparam logic [RC-1:0] RING_FULL = RC'(INCIDENT_DEPTH);
   localparam logic [BC-1:0] BLK_END   = BC'(BLOCK_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_BLK, ST_RING, ST_DONE} state_type;

   // (head + off) mod depth; sum stays below twice the depth
   function automatic logic [RA-1:0] ring_slot(input logic [RA-1:0] base,
                                                input logic [RC-1:0] off);
      logic [RC-1:0] sum;
      sum = {1'b0, base} + off;
      if (sum >= RING_FULL) sum = sum - RING_FULL;
      return sum[RA-1:0];
   endfunction

   state_type state_ff, state_in;

   // latched transaction
   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TS_W-1:0]   now_ff;

   // CSRs
   logic [THR_W-1:0]  thr_ff;
   logic [TS_W-1:0]   iwin_ff;
   logic [TS_W-1:0]   bwin_ff;

   // incident ring: {key, time} per entry
   logic [EW-1:0]     ring_mem_ff [INCIDENT_DEPTH];
   logic [EW-1:0]     ring_rd_ff;
   logic [RA-1:0]     head_ff;
   logic [RC-1:0]     fill_ff;

   // block table: {key, time} per entry plus valid flops
   logic [EW-1:0]     blk_mem_ff [BLOCK_DEPTH];
   logic [EW-1:0]     blk_rd_ff;
   logic [BLOCK_DEPTH-1:0] bvalid_ff;

   // block sweep
   logic [BC-1:0]     b_iss_ff;
   logic              b_pv_ff;
   logic [BA-1:0]     b_pi_ff;
   logic              hit_ff, free_ff, vic_ff;
   logic [BA-1:0]     hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [TS_W-1:0]   vic_age_ff;

   // ring sweep
   logic [RC-1:0]     r_iss_ff;
   logic              r_pv_ff;
   logic [RC-1:0]     kept_ff;
   logic [RC-1:0]     mcnt_ff;
   logic              first_eq_ff;

   // result registers
   logic              rsp_valid_ff;
   logic              rsp_allowed_ff;
   logic              rsp_blocked_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_ovf_ff;

   cmp_res_type       cmp;
   logic [TS_W-1:0]   cmp_stamp, cmp_window;
   logic [KEY_W-1:0]  cmp_key;

   logic              blk_re, ring_re, blk_we, ring_we;
   logic              b_surv, r_surv;
   logic [BA-1:0]     blk_waddr;
   logic [RA-1:0]     ring_raddr, ring_waddr;
   logic [EW-1:0]     ring_wdata;
   logic              r_full, is_report, reached, blk_now;
   logic [RC-1:0]     cnt_all;

   // shared compare unit: block entries in ST_BLK, ring entries otherwise
   assign cmp_stamp  = (state_ff == ST_BLK) ? blk_rd_ff[TS_W-1:0] : ring_rd_ff[TS_W-1:0];
   assign cmp_key    = (state_ff == ST_BLK) ? blk_rd_ff[EW-1:TS_W] : ring_rd_ff[EW-1:TS_W];
   assign cmp_window = (state_ff == ST_BLK) ? bwin_ff : iwin_ff;

   pkib_cmp_unit u_cmp (
      .now_ms    (now_ff),
      .stamp_ms  (cmp_stamp),
      .window_ms (cmp_window),
      .key_a     (key_ff),
      .key_b     (cmp_key),
      .res       (cmp)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign blk_re  = (state_ff == ST_BLK) && (b_iss_ff != BLK_END);
   assign ring_re = (state_ff == ST_RING) && (r_iss_ff != fill_ff);
   assign b_surv  = bvalid_ff[b_pi_ff] && !cmp.expired;
   assign r_surv  = r_pv_ff && !cmp.expired;

   // final-step decisions
   assign is_report = (op_ff == OP_REPORT);
   assign r_full    = (kept_ff == RING_FULL);
   assign cnt_all   = mcnt_ff - RC'(r_full && first_eq_ff) + RC'(1);
   assign reached   = (32'(cnt_all) >= 32'(thr_ff));
   assign blk_now   = is_report && reached;
   assign blk_we    = (state_ff == ST_DONE) && blk_now;
   assign blk_waddr = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : vic_idx_ff);

   assign ring_raddr = ring_slot(head_ff, r_iss_ff);

   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = ring_slot(head_ff, kept_ff);
      ring_wdata = ring_rd_ff;
      if (state_ff == ST_RING) begin
         ring_we = r_surv;
      end else if (state_ff == ST_DONE && is_report) begin
         ring_we    = 1'b1;
         ring_wdata = {key_ff, now_ff};
         // full ring: the new entry lands on the oldest one
         if (r_full) ring_waddr = head_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_BLK;
         ST_BLK:  if (b_iss_ff == BLK_END && !b_pv_ff) state_in = ST_RING;
         ST_RING: if (r_iss_ff == fill_ff && !r_pv_ff) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (blk_re) blk_rd_ff <= blk_mem_ff[b_iss_ff[BA-1:0]];
      if (blk_we) blk_mem_ff[blk_waddr] <= {key_ff, now_ff};
   end

   always_ff @(posedge clock) begin
      if (ring_re) ring_rd_ff <= ring_mem_ff[ring_raddr];
      if (ring_we) ring_mem_ff[ring_waddr] <= ring_wdata;
   end

   // sequencer, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         iwin_ff      <= WIN_RESET;
         bwin_ff      <= WIN_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         bvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         b_pv_ff      <= 1'b0;
         r_pv_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         // one-cycle strobe after the final step
         rsp_valid_ff <= (state_ff == ST_DONE);

         if (csr_valid) begin
            unique case (csr_index)
               CSR_THRESHOLD:  thr_ff  <= csr_wdata[THR_W-1:0];
               CSR_INC_WINDOW: iwin_ff <= csr_wdata;
               CSR_BLK_WINDOW: bwin_ff <= csr_wdata;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff       <= req_opcode;
                  key_ff      <= req_account_key;
                  now_ff      <= req_now_ms;
                  b_iss_ff    <= '0;
                  b_pv_ff     <= 1'b0;
                  hit_ff      <= 1'b0;
                  free_ff     <= 1'b0;
                  vic_ff      <= 1'b0;
                  r_iss_ff    <= '0;
                  r_pv_ff     <= 1'b0;
                  kept_ff     <= '0;
                  mcnt_ff     <= '0;
                  first_eq_ff <= 1'b0;
               end
            end
            ST_BLK: begin
               b_pv_ff <= blk_re;
               b_pi_ff <= b_iss_ff[BA-1:0];
               if (blk_re) b_iss_ff <= b_iss_ff + BC'(1);
               if (b_pv_ff) begin
                  if (bvalid_ff[b_pi_ff] && cmp.expired) bvalid_ff[b_pi_ff] <= 1'b0;
                  if (b_surv && cmp.key_eq) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= b_pi_ff;
                  end
                  if (!b_surv && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= b_pi_ff;
                  end
                  // oldest surviving entry, lowest index on ties
                  if (b_surv && (!vic_ff || cmp.age > vic_age_ff)) begin
                     vic_ff     <= 1'b1;
                     vic_idx_ff <= b_pi_ff;
                     vic_age_ff <= cmp.age;
                  end
               end
            end
            ST_RING: begin
               r_pv_ff <= ring_re;
               if (ring_re) r_iss_ff <= r_iss_ff + RC'(1);
               if (r_surv) begin
                  kept_ff <= kept_ff + RC'(1);
                  if (cmp.key_eq) mcnt_ff <= mcnt_ff + RC'(1);
                  if (kept_ff == '0) first_eq_ff <= cmp.key_eq;
               end
            end
            ST_DONE: begin
               rsp_allowed_ff <= !(hit_ff || blk_now);
               rsp_blocked_ff <= blk_now;
               rsp_ovf_ff     <= is_report &&
                                 (r_full || (blk_now && !hit_ff && !free_ff));
               if (!is_report)
                  rsp_count_ff <= '0;
               else if (32'(cnt_all) > 32'(CNT_SAT))
                  rsp_count_ff <= CNT_SAT;
               else
                  rsp_count_ff <= CNT_W'(cnt_all);
               if (is_report && r_full) begin
                  head_ff <= ring_slot(head_ff, RC'(1));
                  fill_ff <= RING_FULL;
               end else if (is_report) begin
                  fill_ff <= kept_ff + RC'(1);
               end else begin
                  fill_ff <= kept_ff;
               end
               if (blk_now) bvalid_ff[blk_waddr] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_allowed        = rsp_allowed_ff;
   assign rsp_blocked_now    = rsp_blocked_ff;
   assign rsp_incident_count = rsp_count_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   // ring occupancy never exceeds its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= RING_FULL)
      else $error("ring fill beyond depth");

   // an accepted transaction starts the block sweep
   a_start_sweep: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_BLK))
      else $error("accepted transaction did not start sweep");

   // a result strobe comes only from the final step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("result strobe without final step");

   // compaction writes never overtake the read pointer
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RING) |-> (kept_ff <= r_iss_ff))
      else $error("ring compaction overtook reads");

endmodule

### rtl/pkib_cmp_unit.sv
module pkib_cmp_unit
   import pkib_pkg::*;
(
   input  logic [TS_W-1:0]  now_ms,
   input  logic [TS_W-1:0]  stamp_ms,
   input  logic [TS_W-1:0]  window_ms,
   input  logic [KEY_W-1:0] key_a,
   input  logic [KEY_W-1:0] key_b,
   output cmp_res_type      res
);

   logic [TS_W-1:0] age;

   // wrapping age, strictly-greater expiry
   assign age         = now_ms - stamp_ms;
   assign res.age     = age;
   assign res.expired = (age > window_ms);
   assign res.key_eq  = (key_a == key_b);

endmodule
